### rtl/iwf_pkg.sv
// iwf_pkg: shared types, register indexes and constants of the image window filter
// no dependencies; used by the top, front and back modules of the block

package iwf_pkg;

    // row counter width: frame height plus the drain rows and a column remainder
    localparam int ROW_W = 17;
    // widest line store column address carried between front and back
    localparam int LS_ADDR_W = 13;

    localparam int MIDQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 8;

    // register indexes of the configuration port
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FILTER_MODE  = 2'd2;
    localparam logic [1:0] REG_MAX_LEVEL    = 2'd3;

    // filter modes
    localparam logic [1:0] MODE_LAPLACE = 2'd0;
    localparam logic [1:0] MODE_MEAN3   = 2'd1;
    localparam logic [1:0] MODE_MEAN5   = 2'd2;
    localparam logic [1:0] MODE_COPY    = 2'd3;

    // reciprocal multipliers, exact for window sums of 16-bit pixels
    localparam int MUL_W = 22;
    localparam logic [MUL_W-1:0] DIV9_MUL  = 22'd1864136;
    localparam int DIV9_SHIFT = 24;
    localparam logic [MUL_W-1:0] DIV25_MUL = 22'd2684355;
    localparam int DIV25_SHIFT = 26;

    typedef struct packed {
        logic        kind;
        logic [15:0] pixel_in;
    } pixel_item_t;

    typedef struct packed {
        logic [15:0] pixel_out;
        logic        frame_last;
    } result_item_t;

    // classified pixel handed from front to back
    typedef struct packed {
        logic [15:0]          pix;
        logic [LS_ADDR_W-1:0] col;
        logic [1:0]           bank;
        logic                 emit;
        logic                 last;
        logic [1:0]           mode;
        logic [4:0]           row_ok;
        logic [4:0]           col_ok;
    } mid_item_t;

    function automatic logic [1:0] radius_of(input logic [1:0] mode);
        logic [1:0] r;
        case (mode)
            MODE_LAPLACE: r = 2'd1;
            MODE_MEAN3:   r = 2'd1;
            MODE_MEAN5:   r = 2'd2;
            MODE_COPY:    r = 2'd0;
            default:      r = 2'd1;
        endcase
        return r;
    endfunction

endpackage

### rtl/image_window_filter_unit.sv
// image_window_filter_unit: top level of the 3x3 / 5x5 raster window filter
// depends on iwf_pkg, iwf_fifo, iwf_front and iwf_back
//
// usage
//   pixels enter in raster order on a queue-like port: a transaction completes on a
//   rising edge with push high and full low. kind 1 is a flush tick standing for a
//   pixel past the frame end (value zero), used to drain the last rows.
//   results leave on a queue-like port: the oldest result sits on result_item while
//   empty is low and is taken on an edge with pop high. configuration: cfg_we writes
//   cfg_data to register cfg_index at once (width, height, mode, max level); it is
//   written only while the block holds no work, a rule for the user, not enforced.
// timing
//   one pixel per cycle sustained while full is low; the front classifies a pixel in
//   its accept cycle, the back runs a pipeline (line store read, window shift, row sums,
//   reciprocal multiply, clamp). the frame lag is radius rows plus radius pixels.
//   after a write of image_width, full stays high while the column is re-aligned one
//   quotient bit a cycle.
// reset and stalls
//   reset returns registers to their defaults and the position to the frame start;
//   the line store is not cleared. when the receiver stops popping, the output queue
//   fills under a credit check and the pipeline, then the middle queue, then full,
//   hold off further transactions without losing any result.

module image_window_filter_unit #(
    parameter int MAX_WIDTH = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  iwf_pkg::pixel_item_t  pixel_item,
    output logic                  empty,
    input  logic                  pop,
    output iwf_pkg::result_item_t result_item,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = COL_W + 1;
    localparam int MID_W  = $bits(iwf_pkg::mid_item_t);
    localparam int RES_W  = $bits(iwf_pkg::result_item_t);
    localparam int MCNT_W = $clog2(iwf_pkg::MIDQ_DEPTH + 1);
    localparam int OCNT_W = $clog2(iwf_pkg::OUTQ_DEPTH + 1);

    // configuration registers
    logic [10:0] cfg_width_reg;
    logic [15:0] cfg_height_reg;
    logic [1:0]  cfg_mode_reg;
    logic [15:0] cfg_max_reg;

    logic [WID_W-1:0] width_eff;
    logic [15:0]      height_eff;
    logic             width_written;

    // front to back queue
    logic               mid_push, mid_full, mid_pop, mid_empty;
    iwf_pkg::mid_item_t mid_in, mid_out;
    logic [MCNT_W-1:0]  mid_count;

    // back to output queue
    logic                  res_push, res_full;
    iwf_pkg::result_item_t res_item;
    logic [OCNT_W-1:0]     out_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= 11'd640;
            cfg_height_reg <= 16'd480;
            cfg_mode_reg   <= iwf_pkg::MODE_LAPLACE;
            cfg_max_reg    <= 16'd255;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                iwf_pkg::REG_IMAGE_WIDTH:  cfg_width_reg  <= cfg_data[10:0];
                iwf_pkg::REG_IMAGE_HEIGHT: cfg_height_reg <= cfg_data;
                iwf_pkg::REG_FILTER_MODE:  cfg_mode_reg   <= cfg_data[1:0];
                iwf_pkg::REG_MAX_LEVEL:    cfg_max_reg    <= cfg_data;
                default:                   cfg_max_reg    <= cfg_max_reg;
            endcase
        end
    end

    assign width_written = cfg_we && (cfg_index == iwf_pkg::REG_IMAGE_WIDTH);

    // zero width acts as one, widths past the line store act as its size
    always_comb
    begin
        if (32'(cfg_width_reg) > 32'(MAX_WIDTH))
        begin
            width_eff = WID_W'(MAX_WIDTH);
        end
        else if (cfg_width_reg == '0)
        begin
            width_eff = WID_W'(1);
        end
        else
        begin
            width_eff = WID_W'(cfg_width_reg);
        end
        height_eff = (cfg_height_reg == '0) ? 16'd1 : cfg_height_reg;
    end

    iwf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .width         (width_eff),
        .height        (height_eff),
        .mode          (cfg_mode_reg),
        .width_written (width_written),
        .push          (push),
        .pixel_item    (pixel_item),
        .full          (full),
        .mid_full      (mid_full),
        .mid_push      (mid_push),
        .mid_item      (mid_in)
    );

    iwf_fifo #(
        .WIDTH (MID_W),
        .DEPTH (iwf_pkg::MIDQ_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_in),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_out),
        .empty (mid_empty),
        .count (mid_count)
    );

    iwf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mid_item   (mid_out),
        .mid_empty  (mid_empty),
        .mid_pop    (mid_pop),
        .max_level  (cfg_max_reg),
        .outq_count (out_count),
        .res_push   (res_push),
        .res_item   (res_item)
    );

    iwf_fifo #(
        .WIDTH (RES_W),
        .DEPTH (iwf_pkg::OUTQ_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_item),
        .full  (res_full),
        .pop   (pop),
        .rdata (result_item),
        .empty (empty),
        .count (out_count)
    );

    // middle queue never reports more than its depth, and the credit keeps
    // the output queue from refusing a result
    assert property (@(posedge clk) disable iff (!rst_n)
        mid_count <= MCNT_W'(iwf_pkg::MIDQ_DEPTH))
        else $error("middle queue count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result lost at a full output queue");

endmodule

### rtl/iwf_fifo.sv
// iwf_fifo: small register queue with push/full and pop/empty sides
// no package dependency; used between front and back and on the result side

module iwf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic [CNT_W-1:0] count
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/iwf_front.sv
// iwf_front: input position tracking and classification of each pixel
// depends on iwf_pkg; remainder unit re-aligns the column after a width change

module iwf_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int PIXEL_BITS = 16,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int WID_W = COL_W + 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [WID_W-1:0]    width,
    input  logic [15:0]         height,
    input  logic [1:0]          mode,
    input  logic                width_written,
    input  logic                push,
    input  iwf_pkg::pixel_item_t pixel_item,
    output logic                full,
    input  logic                mid_full,
    output logic                mid_push,
    output iwf_pkg::mid_item_t  mid_item
);

    localparam int ROW_W = iwf_pkg::ROW_W;
    localparam int LSA_W = iwf_pkg::LS_ADDR_W;
    localparam int OW    = ROW_W + 2;
    localparam int DW    = WID_W + 3;
    localparam int CNT_W = $clog2(COL_W);

    typedef enum logic [1:0] {
        FS_RUN = 2'b01,
        FS_DIV = 2'b10
    } fstate_t;

    fstate_t          state_reg, state_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] q_reg, q_next;
    logic [COL_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic                 accept;
    logic [1:0]           rad;
    logic [1:0]           borrow;
    logic [ROW_W-1:0]     crow;
    logic signed [DW-1:0] wsg, d, ocol;
    logic signed [OW-1:0] orow, hs;
    logic                 early, past, emit, last;
    logic [4:0]           row_ok, col_ok;
    logic [WID_W-1:0]     col_inc, trial;
    logic                 ge;
    logic [COL_W-1:0]     rem;

    assign full     = (state_reg != FS_RUN) || mid_full;
    assign accept   = push && !full;
    assign mid_push = accept;

    // centre position relative to the canonical input position
    always_comb
    begin
        logic signed [OW-1:0] rr;
        logic signed [DW-1:0] cc;
        rad  = iwf_pkg::radius_of(mode);
        crow = in_row_reg + ROW_W'(q_reg);
        wsg  = $signed(DW'(width));
        d    = $signed(DW'(r_reg)) - $signed(DW'(rad));
        if (d >= 0)
        begin
            ocol   = d;
            borrow = 2'd0;
        end
        else if (d + wsg >= 0)
        begin
            ocol   = d + wsg;
            borrow = 2'd1;
        end
        else
        begin
            ocol   = d + wsg + wsg;
            borrow = 2'd2;
        end
        orow   = $signed(OW'(crow)) - $signed(OW'(rad)) - $signed(OW'(borrow));
        hs     = $signed(OW'(height));
        early  = (orow < 0);
        past   = !early && (orow >= hs);
        emit   = !early && !past;
        last   = emit && (orow == hs - 1) && (ocol == wsg - 1);
        for (int a = 0; a < 5; a++)
        begin
            rr        = orow + $signed(OW'(a)) - $signed(OW'(2));
            cc        = ocol + $signed(DW'(a)) - $signed(DW'(2));
            row_ok[a] = (rr >= 0) && (rr < hs);
            col_ok[a] = (cc >= 0) && (cc < wsg);
        end
    end

    always_comb
    begin
        mid_item.pix    = pixel_item.kind ? 16'd0 : 16'(pixel_item.pixel_in[PIXEL_BITS-1:0]);
        mid_item.col    = LSA_W'(in_col_reg);
        mid_item.bank   = in_row_reg[1:0];
        mid_item.emit   = emit;
        mid_item.last   = last;
        mid_item.mode   = mode;
        mid_item.row_ok = row_ok;
        mid_item.col_ok = col_ok;
    end

    // one quotient bit a cycle of column / width
    always_comb
    begin
        trial = {r_reg, in_col_reg[cnt_reg]};
        ge    = (trial >= width);
        rem   = ge ? COL_W'(trial - width) : trial[COL_W-1:0];
    end

    always_comb
    begin
        col_inc     = WID_W'(in_col_reg) + 1'b1;
        state_next  = state_reg;
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        cnt_next    = cnt_reg;
        if (width_written)
        begin
            state_next = FS_DIV;
            cnt_next   = CNT_W'(COL_W - 1);
            q_next     = '0;
            r_next     = '0;
        end
        else
        begin
            case (state_reg)
                FS_RUN:
                begin
                    if (accept)
                    begin
                        if (past || last)
                        begin
                            in_col_next = '0;
                            in_row_next = '0;
                        end
                        else if (col_inc >= width)
                        begin
                            in_col_next = '0;
                            in_row_next = in_row_reg + 1'b1;
                        end
                        else
                        begin
                            in_col_next = col_inc[COL_W-1:0];
                        end
                        q_next = '0;
                        r_next = in_col_next;
                    end
                end
                FS_DIV:
                begin
                    q_next = {q_reg[COL_W-2:0], ge};
                    r_next = rem;
                    if (cnt_reg == '0)
                    begin
                        state_next = FS_RUN;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_next = FS_RUN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FS_RUN;
            in_col_reg <= '0;
            in_row_reg <= '0;
            q_reg      <= '0;
            r_reg      <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            q_reg      <= q_next;
            r_reg      <= r_next;
            cnt_reg    <= cnt_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (mid_push && mid_item.last) |=> (in_col_reg == '0 && in_row_reg == '0))
        else $error("frame end did not restart the input position");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FS_DIV) |-> !mid_push)
        else $error("pixel taken while column remainder in progress");

endmodule

### rtl/iwf_back.sv
// iwf_back: line store, 5x5 window, masked sums, reciprocal divide and clamp
// depends on iwf_pkg; results leave towards the output queue under a credit check

module iwf_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int PIXEL_BITS = 16,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int OCNT_W = $clog2(iwf_pkg::OUTQ_DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  iwf_pkg::mid_item_t     mid_item,
    input  logic                   mid_empty,
    output logic                   mid_pop,
    input  logic [15:0]            max_level,
    input  logic [OCNT_W-1:0]      outq_count,
    output logic                   res_push,
    output iwf_pkg::result_item_t  res_item
);

    localparam int PB      = PIXEL_BITS;
    localparam int RS_W    = PB + 3;
    localparam int SUM_W   = PB + 5;
    localparam int LAP_W   = PB + 4;
    localparam int PROD_W  = SUM_W + iwf_pkg::MUL_W;
    localparam int CLAMP_W = PB + 18;

    logic [COL_W-1:0] addr;
    logic [PB-1:0]    rd_data_reg [4];
    logic [PB-1:0]    win_reg [5][5];
    logic [2:0]       inflight;
    logic             credit;

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    iwf_pkg::mid_item_t s1_item_reg, s2_item_reg, s3_item_reg, s4_item_reg;

    logic [RS_W-1:0]         rowsum_reg [5];
    logic [RS_W-1:0]         rowsum_next [5];
    logic signed [LAP_W-1:0] lap3_reg, lap4_reg, lap_next;
    logic [PB-1:0]           ctr3_reg, ctr4_reg, ctr_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [SUM_W-1:0]        sum;
    logic [PB-1:0]           t [5][5];
    logic [PB-1:0]           quot;
    logic signed [CLAMP_W-1:0] val, lim;

    // credit: never more in flight than the output queue can still hold
    assign inflight = 3'(s1_valid_reg) + 3'(s2_valid_reg) + 3'(s3_valid_reg)
                    + 3'(s4_valid_reg);
    assign credit   = (OCNT_W'(inflight) + outq_count) < OCNT_W'(iwf_pkg::OUTQ_DEPTH);
    assign mid_pop  = !mid_empty && credit;
    assign addr     = mid_item.col[COL_W-1:0];

    // four row banks, all read once per pixel and only the pixel's row bank written, read before write
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [PB-1:0] bank_mem [MAX_WIDTH];
        always_ff @(posedge clk)
        begin
            if (mid_pop)
            begin
                rd_data_reg[b] <= bank_mem[addr];
                if (mid_item.bank == 2'(b))
                begin
                    bank_mem[addr] <= mid_item.pix[PB-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            for (int i = 0; i < 5; i++)
            begin
                for (int j = 0; j < 5; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            s1_valid_reg <= mid_pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            if (s1_valid_reg)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        win_reg[i][j] <= win_reg[i][j+1];
                    end
                end
                for (int k = 0; k < 4; k++)
                begin
                    win_reg[k][4] <= rd_data_reg[2'(s1_item_reg.bank + 2'(k))];
                end
                win_reg[4][4] <= s1_item_reg.pix[PB-1:0];
            end
        end
    end

    // masked taps around the centre, by radius
    always_comb
    begin
        int ri;
        logic [2:0] ia, ib;
        ri = int'(iwf_pkg::radius_of(s2_item_reg.mode));
        for (int a = 0; a < 5; a++)
        begin
            for (int c = 0; c < 5; c++)
            begin
                ia = 3'(a + 2 - ri);
                ib = 3'(c + 2 - ri);
                t[a][c] = '0;
                if ((a + ri >= 2) && (a <= ri + 2) && (c + ri >= 2) && (c <= ri + 2)
                    && s2_item_reg.row_ok[a] && s2_item_reg.col_ok[c])
                begin
                    t[a][c] = win_reg[ia][ib];
                end
            end
        end
        for (int a = 0; a < 5; a++)
        begin
            rowsum_next[a] = RS_W'(t[a][0]) + RS_W'(t[a][1]) + RS_W'(t[a][2])
                           + RS_W'(t[a][3]) + RS_W'(t[a][4]);
        end
        lap_next = $signed(LAP_W'(t[2][2]) << 2) - $signed(LAP_W'(t[1][2]))
                 - $signed(LAP_W'(t[3][2])) - $signed(LAP_W'(t[2][1]))
                 - $signed(LAP_W'(t[2][3]));
        ctr_next = t[2][2];
    end

    always_comb
    begin
        sum = '0;
        for (int a = 0; a < 5; a++)
        begin
            sum = sum + SUM_W'(rowsum_reg[a]);
        end
        if (s3_item_reg.mode == iwf_pkg::MODE_MEAN5)
        begin
            prod_next = sum * iwf_pkg::DIV25_MUL;
        end
        else
        begin
            prod_next = sum * iwf_pkg::DIV9_MUL;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= mid_item;
        s2_item_reg <= s1_item_reg;
        s3_item_reg <= s2_item_reg;
        s4_item_reg <= s3_item_reg;
        for (int a = 0; a < 5; a++)
        begin
            rowsum_reg[a] <= rowsum_next[a];
        end
        lap3_reg <= lap_next;
        ctr3_reg <= ctr_next;
        lap4_reg <= lap3_reg;
        ctr4_reg <= ctr3_reg;
        prod_reg <= prod_next;
    end

    // final select and clamp
    always_comb
    begin
        if (s4_item_reg.mode == iwf_pkg::MODE_MEAN5)
        begin
            quot = prod_reg[iwf_pkg::DIV25_SHIFT +: PB];
        end
        else
        begin
            quot = prod_reg[iwf_pkg::DIV9_SHIFT +: PB];
        end
        case (s4_item_reg.mode)
            iwf_pkg::MODE_LAPLACE: val = CLAMP_W'(lap4_reg);
            iwf_pkg::MODE_COPY:    val = $signed(CLAMP_W'(ctr4_reg));
            default:               val = $signed(CLAMP_W'(quot));
        endcase
        lim = $signed(CLAMP_W'(max_level));
        if (val < 0)
        begin
            res_item.pixel_out = 16'd0;
        end
        else if (val > lim)
        begin
            res_item.pixel_out = max_level;
        end
        else
        begin
            res_item.pixel_out = val[15:0];
        end
        res_item.frame_last = s4_item_reg.last;
        res_push = s4_valid_reg && s4_item_reg.emit;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (outq_count < OCNT_W'(iwf_pkg::OUTQ_DEPTH)))
        else $error("result pushed into a full output queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res_item.pixel_out <= max_level))
        else $error("result above the upper clamp");

endmodule
